/* rtl/rlmm_pkg.sv */
// ----------------------------------------------------------------------------
// rlmm_pkg
// Shared types and constants of the RGB line min-max normalizer.
// ----------------------------------------------------------------------------
package rlmm_pkg;

	// Channel codes; code 3 carries no channel.
	localparam int unsigned NUM_CH = 3;
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	localparam logic [2:0] FULL_MASK = 3'h7;

	// Range modes; the unused code behaves as auto.
	localparam logic [1:0] MODE_AUTO      = 2'd0;
	localparam logic [1:0] MODE_FIXED_255 = 2'd1;
	localparam logic [1:0] MODE_FIXED_100 = 2'd2;

	localparam logic signed [15:0] SAMPLE_MAX   = 16'sh7fff;
	localparam logic signed [15:0] SAMPLE_MIN   = 16'sh8000;
	localparam logic signed [15:0] FIXED_HI_255 = 16'sd255;
	localparam logic signed [15:0] FIXED_HI_100 = 16'sd100;
	localparam logic [7:0]         LEVEL_MAX    = 8'd255;

	typedef struct packed {
		logic [1:0]         channel;
		logic signed [15:0] sample_value;
		logic               vector_last;
	} in_t;

	typedef struct packed {
		logic [5:0] pixel_index;
		logic [7:0] red_level;
		logic [7:0] green_level;
		logic [7:0] blue_level;
		logic       line_end;
	} out_t;

	// Store write control from the front end.
	typedef struct packed {
		logic       en;
		logic [1:0] lane;
	} wr_ctl_t;

	// Line job posted by the front end.
	typedef struct packed {
		logic       valid;
		logic [1:0] mode;
	} job_t;

	// Back end status seen by the front end.
	typedef struct packed {
		logic take;
		logic busy;
	} back_stat_t;

endpackage

/* rtl/rlmm_div.sv */
// ----------------------------------------------------------------------------
// rlmm_div
// Restoring divider for one color lane: 8-bit quotient, saturated to 0..255.
// ----------------------------------------------------------------------------
module rlmm_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [24:0] num,
	input  logic [15:0]        den,
	output logic               busy,
	output logic [7:0]         q
);

	logic        busy_q;
	logic [3:0]  step_q;
	logic [24:0] r_q;
	logic [15:0] den_q;
	logic        neg_q;
	logic        sat_q;
	logic [7:0]  quo_q;
	logic [24:0] trial;
	logic        ge;

	assign trial = {9'b0, den_q} << step_q;
	assign ge    = r_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && step_q == 4'd0) begin
			busy_q <= 1'b0;
		end
	end

	// First step only checks for saturation, then one quotient bit a cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			r_q    <= num;
			den_q  <= den;
			neg_q  <= num[24];
			sat_q  <= 1'b0;
			quo_q  <= '0;
			step_q <= 4'd8;
		end else if (busy_q) begin
			if (step_q == 4'd8) begin
				sat_q <= ge;
			end else if (ge) begin
				r_q                <= r_q - trial;
				quo_q[step_q[2:0]] <= 1'b1;
			end
			step_q <= step_q - 4'd1;
		end
	end

	assign busy = busy_q;
	assign q    = neg_q ? 8'd0 : (sat_q ? rlmm_pkg::LEVEL_MAX : quo_q);

endmodule

/* rtl/rlmm_front.sv */
// ----------------------------------------------------------------------------
// rlmm_front
// Input side: per-channel fill counters, lengths and received mask; writes
// the pixel store and posts a line job when all three channels are in.
// ----------------------------------------------------------------------------
module rlmm_front #(
	parameter  int LINE_PIXELS = 64,
	localparam int AW = (LINE_PIXELS > 1) ? $clog2(LINE_PIXELS) : 1,
	localparam int CW = $clog2(LINE_PIXELS + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  rlmm_pkg::in_t          sample,
	input  logic [1:0]             range_mode,
	output rlmm_pkg::wr_ctl_t      st_wr,
	output logic [AW-1:0]          st_addr,
	output logic signed [15:0]     st_data,
	output rlmm_pkg::job_t         job,
	output logic [CW-1:0]          job_width,
	input  rlmm_pkg::back_stat_t   back_stat
);

	logic [CW-1:0] fill_q [rlmm_pkg::NUM_CH];
	logic [CW-1:0] len_q  [rlmm_pkg::NUM_CH];
	logic [2:0]    mask_q;
	rlmm_pkg::job_t job_q;
	logic [CW-1:0] job_width_q;

	logic          accept;
	logic          last;
	logic [2:0]    hit;
	logic [2:0]    room;
	logic [CW-1:0] fill_inc [rlmm_pkg::NUM_CH];
	logic [CW-1:0] fill_nx  [rlmm_pkg::NUM_CH];
	logic [CW-1:0] len_nx   [rlmm_pkg::NUM_CH];
	logic [2:0]    mask_nx;
	logic [CW-1:0] width_01;
	logic [CW-1:0] width_nx;
	logic          complete;

	assign full   = job_q.valid | back_stat.busy;
	assign accept = push & ~full;
	assign last   = sample.vector_last;

	always_comb begin
		st_addr = '0;
		for (int c = 0; c < rlmm_pkg::NUM_CH; c++) begin
			hit[c]      = accept && (sample.channel == 2'(c));
			room[c]     = fill_q[c] < CW'(LINE_PIXELS);
			fill_inc[c] = fill_q[c] + CW'(room[c]);
			fill_nx[c]  = hit[c] ? (last ? '0 : fill_inc[c]) : fill_q[c];
			len_nx[c]   = (hit[c] && last) ? fill_inc[c] : len_q[c];
			if (hit[c]) begin
				st_addr = fill_q[c][AW-1:0];
			end
		end
		mask_nx  = mask_q | ({3{last}} & hit);
		width_01 = (len_nx[1] < len_nx[0]) ? len_nx[1] : len_nx[0];
		width_nx = (len_nx[2] < width_01) ? len_nx[2] : width_01;
		complete = (|hit) && last && (mask_nx == rlmm_pkg::FULL_MASK) && (width_nx != '0);
	end

	// Drop elements past the end of the line.
	assign st_wr.en   = |(hit & room);
	assign st_wr.lane = sample.channel;
	assign st_data    = sample.sample_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < rlmm_pkg::NUM_CH; c++) begin
				fill_q[c] <= '0;
				len_q[c]  <= '0;
			end
			mask_q      <= '0;
			job_q       <= '0;
			job_width_q <= '0;
		end else begin
			if (accept) begin
				for (int c = 0; c < rlmm_pkg::NUM_CH; c++) begin
					fill_q[c] <= fill_nx[c];
					len_q[c]  <= len_nx[c];
				end
				mask_q <= complete ? '0 : mask_nx;
			end
			if (complete) begin
				job_q.valid <= 1'b1;
				job_q.mode  <= range_mode;
				job_width_q <= width_nx;
			end else if (back_stat.take) begin
				job_q.valid <= 1'b0;
			end
		end
	end

	assign job       = job_q;
	assign job_width = job_width_q;

endmodule

/* rtl/rlmm_back.sv */
// ----------------------------------------------------------------------------
// rlmm_back
// Output side: pixel store, min-max scan and per-pixel scaling through three
// serial divider lanes.
// ----------------------------------------------------------------------------
module rlmm_back #(
	parameter  int LINE_PIXELS = 64,
	localparam int AW = (LINE_PIXELS > 1) ? $clog2(LINE_PIXELS) : 1,
	localparam int CW = $clog2(LINE_PIXELS + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rlmm_pkg::wr_ctl_t      st_wr,
	input  logic [AW-1:0]          st_addr,
	input  logic signed [15:0]     st_data,
	input  rlmm_pkg::job_t         job,
	input  logic [CW-1:0]          job_width,
	output rlmm_pkg::back_stat_t   back_stat,
	output logic                   res_push,
	output rlmm_pkg::out_t         res,
	input  logic                   res_full
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SCAN = 6'b000010,
		S_PREP = 6'b000100,
		S_READ = 6'b001000,
		S_LOAD = 6'b010000,
		S_DIV  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic              scan_v_s1;
	logic [CW-1:0]     width_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     pix_q;
	logic signed [15:0] lo_q, hi_q;
	logic [15:0]       range_q;
	logic [15:0]       range_raw;

	logic [AW-1:0]     rd_addr;
	logic signed [15:0] rd_s1 [rlmm_pkg::NUM_CH];
	logic signed [15:0] lo_c, hi_c;
	logic signed [16:0] diff [rlmm_pkg::NUM_CH];
	logic signed [24:0] num  [rlmm_pkg::NUM_CH];
	logic [2:0]        div_busy;
	logic [7:0]        lvl [rlmm_pkg::NUM_CH];
	logic              div_start;
	logic              div_idle;
	logic              last_pix;
	logic              take;
	logic              auto_mode;
	logic              scan_more;

	assign take      = (state_q == S_IDLE) && job.valid;
	assign auto_mode = (job.mode != rlmm_pkg::MODE_FIXED_255) &&
	                   (job.mode != rlmm_pkg::MODE_FIXED_100);
	assign scan_more = cnt_q < width_q;
	assign rd_addr   = (state_q == S_SCAN) ? cnt_q[AW-1:0] : pix_q[AW-1:0];
	assign div_start = state_q == S_LOAD;
	assign div_idle  = div_busy == 3'b000;
	assign last_pix  = pix_q == (width_q - CW'(1));
	assign res_push  = (state_q == S_DIV) && div_idle && !res_full;
	assign range_raw = 16'(hi_q - lo_q);

	// Pixel store: one 16-bit memory per color lane, registered read.
	for (genvar l = 0; l < rlmm_pkg::NUM_CH; l++) begin : g_lane
		logic signed [15:0] lane_mem_q [LINE_PIXELS];

		always_ff @(posedge clk) begin
			if (st_wr.en && st_wr.lane == 2'(l)) begin
				lane_mem_q[st_addr] <= st_data;
			end
			rd_s1[l] <= lane_mem_q[rd_addr];
		end

		assign diff[l] = 17'(rd_s1[l]) - 17'(lo_q);
		assign num[l]  = $signed({diff[l], 8'b0}) - 25'(diff[l]);

		rlmm_div u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (div_start),
			.num    (num[l]),
			.den    (range_q),
			.busy   (div_busy[l]),
			.q      (lvl[l])
		);
	end

	always_comb begin
		lo_c = lo_q;
		hi_c = hi_q;
		for (int l = 0; l < rlmm_pkg::NUM_CH; l++) begin
			if (rd_s1[l] < lo_c) begin
				lo_c = rd_s1[l];
			end
			if (rd_s1[l] > hi_c) begin
				hi_c = rd_s1[l];
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (job.valid) begin
					state_d = auto_mode ? S_SCAN : S_PREP;
				end
			end
			S_SCAN: begin
				if (!scan_more && !scan_v_s1) begin
					state_d = S_PREP;
				end
			end
			S_PREP: state_d = S_READ;
			S_READ: state_d = S_LOAD;
			S_LOAD: state_d = S_DIV;
			S_DIV: begin
				if (res_push) begin
					state_d = last_pix ? S_IDLE : S_READ;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			scan_v_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			scan_v_s1 <= (state_q == S_SCAN) && scan_more;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (job.valid) begin
					width_q <= job_width;
					cnt_q   <= '0;
					pix_q   <= '0;
					unique case (job.mode)
						rlmm_pkg::MODE_FIXED_255: begin
							lo_q <= '0;
							hi_q <= rlmm_pkg::FIXED_HI_255;
						end
						rlmm_pkg::MODE_FIXED_100: begin
							lo_q <= '0;
							hi_q <= rlmm_pkg::FIXED_HI_100;
						end
						default: begin
							lo_q <= rlmm_pkg::SAMPLE_MAX;
							hi_q <= rlmm_pkg::SAMPLE_MIN;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (scan_more) begin
					cnt_q <= cnt_q + CW'(1);
				end
				if (scan_v_s1) begin
					lo_q <= lo_c;
					hi_q <= hi_c;
				end
			end
			S_PREP: begin
				range_q <= (range_raw == 16'd0) ? 16'd1 : range_raw;
			end
			S_DIV: begin
				if (res_push) begin
					pix_q <= pix_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign back_stat.take = take;
	assign back_stat.busy = state_q != S_IDLE;

	assign res.pixel_index = 6'(pix_q);
	assign res.red_level   = lvl[0];
	assign res.green_level = lvl[1];
	assign res.blue_level  = lvl[2];
	assign res.line_end    = last_pix;

endmodule

/* rtl/rlmm_fifo.sv */
// ----------------------------------------------------------------------------
// rlmm_fifo
// Two-entry result queue between the back end and the output port.
// ----------------------------------------------------------------------------
module rlmm_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rlmm_pkg::out_t din,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output rlmm_pkg::out_t dout
);

	localparam logic [1:0] DEPTH = 2'd2;

	rlmm_pkg::out_t ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full    = cnt_q == DEPTH;
	assign empty   = cnt_q == 2'd0;
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign dout    = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= ~wp_q;
			end
			if (do_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

/* rtl/rgb_line_min_max_normalizer.sv */
// ----------------------------------------------------------------------------
// rgb_line_min_max_normalizer
// Collects a camera line as red, green and blue vectors and emits every pixel
// contrast-stretched to 0..255 over the auto or fixed value range.
// ----------------------------------------------------------------------------
//
//  port group          | handshake        | moves
//  --------------------+------------------+-----------------------------------
//  sample (in)         | push / full      | channel, sample_value, vector_last
//  pixel (out)         | pop / empty      | index, three levels, line_end
//  cfg                 | cfg_wr_en        | range_mode, no read-back
//
//  A plain element leaves full low. The element that completes a line holds
//  full high until the last pixel enters the result queue: the job is handed
//  over, a min-max scan runs over the line (auto mode only), a setup state
//  computes the range, then each pixel is scaled by the 9-step serial
//  dividers run in three parallel lanes.
//  A full result queue stalls the back end in place. Reset clears the fill
//  counters, lengths, the mask and the mode; the store needs no clearing pass.
//
module rgb_line_min_max_normalizer #(
	parameter int LINE_PIXELS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  rlmm_pkg::in_t  sample,
	output logic           empty,
	input  logic           pop,
	output rlmm_pkg::out_t pixel,
	input  logic           cfg_wr_en,
	input  logic [1:0]     cfg_wr_data
);

	localparam int AW = (LINE_PIXELS > 1) ? $clog2(LINE_PIXELS) : 1;
	localparam int CW = $clog2(LINE_PIXELS + 1);

	logic [1:0]           range_mode_q;
	rlmm_pkg::wr_ctl_t    st_wr;
	logic [AW-1:0]        st_addr;
	logic signed [15:0]   st_data;
	rlmm_pkg::job_t       job;
	logic [CW-1:0]        job_width;
	rlmm_pkg::back_stat_t back_stat;
	logic                 res_push;
	logic                 res_full;
	rlmm_pkg::out_t       res;

	// Hold the range mode; written only while the block is idle by the user, as the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_mode_q <= rlmm_pkg::MODE_AUTO;
		end else if (cfg_wr_en) begin
			range_mode_q <= cfg_wr_data;
		end
	end

	// Front end: accept elements, advance fill counters, write the store and
	// post a job once red, green and blue are all in.
	rlmm_front #(
		.LINE_PIXELS (LINE_PIXELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.sample     (sample),
		.range_mode (range_mode_q),
		.st_wr      (st_wr),
		.st_addr    (st_addr),
		.st_data    (st_data),
		.job        (job),
		.job_width  (job_width),
		.back_stat  (back_stat)
	);

	// Back end: scan for the range (auto mode only), then scale and transfer pixel by pixel.
	rlmm_back #(
		.LINE_PIXELS (LINE_PIXELS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.st_wr     (st_wr),
		.st_addr   (st_addr),
		.st_data   (st_data),
		.job       (job),
		.job_width (job_width),
		.back_stat (back_stat),
		.res_push  (res_push),
		.res       (res),
		.res_full  (res_full)
	);

	// Result queue decouples the back end from the consumer.
	rlmm_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res),
		.full   (res_full),
		.pop    (pop),
		.empty  (empty),
		.dout   (pixel)
	);

`ifndef SYNTHESIS
	a_no_write_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.busy |-> !st_wr.en)
		else $error("store written while the back end reads it");

	a_job_taken: assert property (@(posedge clk) disable iff (!arst_n)
		job.valid && !back_stat.busy |=> back_stat.busy)
		else $error("posted job not taken by idle back end");

	a_full_with_job: assert property (@(posedge clk) disable iff (!arst_n)
		job.valid |-> full)
		else $error("input open while a job is pending");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full queue");

	a_idle_after_line: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res.line_end |=> !back_stat.busy)
		else $error("back end still busy after the line end");
`endif

endmodule
